// ----- rtl/core/hps_pkg.sv -----
package hps_pkg;

  // field widths fixed by the interface
  localparam int TimerW   = 16;
  localparam int RoundW   = 4;
  localparam int LevelW   = 3;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // default sizing of the pwm and the level table
  localparam int PwmStepsDef   = 100;
  localparam int LevelCountDef = 5;

  // operation codes
  localparam logic [OpW-1:0] OP_TICK = 2'd0;
  localparam logic [OpW-1:0] OP_FIRE = 2'd1;
  localparam logic [OpW-1:0] OP_STOP = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ON_TIME   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROUNDS    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PWM_EN    = 2'd3;

  // reset values of the configuration registers
  localparam logic [TimerW-1:0] OnTimeRst   = 16'd10000;
  localparam logic [TimerW-1:0] OffTimeRst  = 16'd10000;
  localparam logic [RoundW-1:0] RoundsRst   = 4'd6;
  localparam logic              PwmEnRst    = 1'b1;

  localparam logic [RoundW-1:0] RoundMax = '1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TimerW-1:0] on_time;
    logic [TimerW-1:0] off_time;
    logic [RoundW-1:0] round_total;
    logic              pwm_enable;
  } cfg_t;

  typedef struct packed {
    logic              motor_drive;
    logic              busy;
    phase_t            phase;
    logic [RoundW-1:0] rounds_done;
    logic              burst_done;
  } result_t;

endpackage

// ----- rtl/core/hps_cfg_regs.sv -----
module hps_cfg_regs
  import hps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_ON_TIME:  cfg_nxt.on_time     = wr_data[TimerW-1:0];
        CFG_OFF_TIME: cfg_nxt.off_time    = wr_data[TimerW-1:0];
        CFG_ROUNDS:   cfg_nxt.round_total = wr_data[RoundW-1:0];
        CFG_PWM_EN:   cfg_nxt.pwm_enable  = wr_data[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time     <= OnTimeRst;
      cfg_r.off_time    <= OffTimeRst;
      cfg_r.round_total <= RoundsRst;
      cfg_r.pwm_enable  <= PwmEnRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/hps_step.sv -----
module hps_step
  import hps_pkg::*;
#(
  parameter int PWM_STEPS   = PwmStepsDef,
  parameter int LEVEL_COUNT = LevelCountDef
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [OpW-1:0]    operation,
  input  logic [LevelW-1:0] level,
  input  cfg_t              cfg,
  output result_t           result
);

  localparam int PwmW    = $clog2(PWM_STEPS);
  localparam int DutyW   = $clog2(PWM_STEPS + 1);
  localparam int LvlSlots = 1 << LevelW;

  localparam logic [PwmW-1:0]   PwmLast  = PwmW'(PWM_STEPS - 1);
  localparam logic [LevelW-1:0] LevelTop = LevelW'(LEVEL_COUNT - 1);

  phase_t            phase_r, phase_nxt;
  logic [RoundW-1:0] round_r, round_nxt;
  logic [LevelW-1:0] level_r, level_nxt;
  logic [TimerW-1:0] timer_r, timer_nxt;
  logic [PwmW-1:0]   pwm_r,   pwm_nxt;
  logic              done;

  logic [TimerW-1:0] timer_inc;
  logic [RoundW-1:0] round_sat;
  logic [PwmW-1:0]   pwm_inc;
  logic [DutyW-1:0]  duty [LvlSlots];
  logic              drive;

  // duty threshold per level, worked out at elaboration
  for (genvar g = 0; g < LvlSlots; g++) begin : g_duty
    assign duty[g] = DutyW'((PWM_STEPS * (g + 1)) / LEVEL_COUNT);
  end

  assign timer_inc = timer_r + 1'b1;
  assign round_sat = (round_r != RoundMax) ? round_r + 1'b1 : round_r;
  assign pwm_inc   = (pwm_r == PwmLast) ? '0 : pwm_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    round_nxt = round_r;
    level_nxt = level_r;
    timer_nxt = timer_r;
    pwm_nxt   = pwm_r;
    done      = 1'b0;
    case (operation)
      OP_TICK: begin
        pwm_nxt = pwm_inc;
        case (phase_r)
          PH_ON: begin
            if (timer_inc >= cfg.on_time || timer_inc == '0) begin
              timer_nxt = '0;
              round_nxt = round_sat;
              if (round_sat >= cfg.round_total) begin
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = PH_OFF;
              end
            end else begin
              timer_nxt = timer_inc;
            end
          end
          PH_OFF: begin
            if (timer_inc >= cfg.off_time || timer_inc == '0) begin
              timer_nxt = '0;
              phase_nxt = PH_ON;
            end else begin
              timer_nxt = timer_inc;
            end
          end
          default: timer_nxt = '0;
        endcase
      end
      OP_FIRE: begin
        level_nxt = (level > LevelTop) ? LevelTop : level;
        round_nxt = '0;
        phase_nxt = PH_ON;
        timer_nxt = '0;
        pwm_nxt   = '0;
      end
      OP_STOP: begin
        phase_nxt = PH_IDLE;
        round_nxt = '0;
        timer_nxt = '0;
      end
      default: ;  // unused code leaves the state alone
    endcase
  end

  // drive level after the update
  always_comb begin
    if (phase_nxt != PH_ON) begin
      drive = 1'b0;
    end else if (!cfg.pwm_enable) begin
      drive = 1'b1;
    end else begin
      drive = (DutyW'(pwm_nxt) < duty[level_nxt]);
    end
  end

  always_comb begin
    result.motor_drive = drive;
    result.busy        = (phase_nxt != PH_IDLE);
    result.phase       = phase_nxt;
    result.rounds_done = round_nxt;
    result.burst_done  = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      round_r <= '0;
      level_r <= '0;
      timer_r <= '0;
      pwm_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      round_r <= round_nxt;
      level_r <= level_nxt;
      timer_r <= timer_nxt;
      pwm_r   <= pwm_nxt;
    end
  end

endmodule

// ----- rtl/core/haptic_pulse_sequencer.sv -----
// haptic burst sequencer: one item in, one result out, at up to one item per clock.
// an item is taken in the cycle it is presented unless the result register still holds
// an earlier result that the far side is stalling; the state update and the result are
// worked out in that same cycle and the result is registered for the next cycle. tick items
// advance the pwm counter and the phase timer, fire restarts a burst at the clamped
// level, stop drops back to idle with no done pulse. configuration writes are always
// taken (cfg_ready is tied high) and act on the next item.
module haptic_pulse_sequencer
  import hps_pkg::*;
#(
  parameter int PWM_STEPS   = PwmStepsDef,
  parameter int LEVEL_COUNT = LevelCountDef
)
(
  input  logic                clk,
  input  logic                rst_n,
  // item input
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OpW-1:0]      in_operation,
  input  logic [LevelW-1:0]   in_level,
  // result output
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_motor_drive,
  output logic                out_busy_res,
  output logic [1:0]          out_phase_code,
  output logic [RoundW-1:0]   out_rounds_done,
  output logic                out_burst_done,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  cfg_t    cfg;
  result_t step_res;
  result_t res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;

  // result register is free when empty or being drained this cycle
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  hps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  hps_step #(
    .PWM_STEPS   (PWM_STEPS),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .level     (in_level),
    .cfg       (cfg),
    .result    (step_res)
  );

  // valid stays while stalled, otherwise follows the accept
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, loaded only on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_drive = res_r.motor_drive;
  assign out_busy_res    = res_r.busy;
  assign out_phase_code  = res_r.phase;
  assign out_rounds_done = res_r.rounds_done;
  assign out_burst_done  = res_r.burst_done;

endmodule
